### rtl/core/sch_pkg.sv
// Package for the sphere/capsule hit test.
// Holds the coordinate width and every datapath width derived from it.
// No dependencies.
package sch_pkg;

   localparam int CW    = 24;               // coordinate width, 8 fraction bits
   localparam int RW    = 22;               // radius width
   localparam int DW    = CW + 1;           // coordinate difference
   localparam int PW    = 2 * DW;           // product of two differences
   localparam int SW    = PW + 2;           // sum of three products, cross term
   localparam int LW    = 2 * CW + 2;       // squared segment length, unsigned
   localparam int RSW   = RW + 1;           // summed radii
   localparam int XW    = 2 * CW + 2;       // magnitude of a cross component
   localparam int XLO   = XW / 2;
   localparam int XHI   = XW - XLO;
   localparam int SQW   = 2 * XW;           // square of a cross component
   localparam int LHSW  = SQW + 2;          // squared cross product length
   localparam int LLO   = LW / 2;
   localparam int LHI   = LW - LLO;
   localparam int RLW   = LW + RSW;         // R * L
   localparam int RLC   = (RLW + 2) / 3;    // chunk of R * L
   localparam int RHSW  = RLW + RSW;        // R * R * L

endpackage

### rtl/core/sch_xsq.sv
// Two-stage unsigned squarer for one cross-product component.
// The operand is split in halves so each multiplier stays narrow.
// Depends on sch_pkg.
module sch_xsq
   import sch_pkg::*;
(
   input  logic           clock,
   input  logic           en,
   input  logic [XW-1:0]  x,
   output logic [SQW-1:0] sq
);

   logic [XHI-1:0]       xh;
   logic [XLO-1:0]       xl;
   logic [2*XHI-1:0]     hh_ff, hh_in;
   logic [XHI+XLO-1:0]   hl_ff, hl_in;
   logic [2*XLO-1:0]     ll_ff, ll_in;
   logic [SQW-1:0]       sq_ff, sq_in;

   assign xh    = x[XW-1:XLO];
   assign xl    = x[XLO-1:0];
   assign hh_in = (2*XHI)'(xh) * (2*XHI)'(xh);
   assign hl_in = (XHI+XLO)'(xh) * (XHI+XLO)'(xl);
   assign ll_in = (2*XLO)'(xl) * (2*XLO)'(xl);

   // x^2 = hh * 2^(2*lo) + 2 * hl * 2^lo + ll
   assign sq_in = (SQW'(hh_ff) << (2 * XLO)) + (SQW'(hl_ff) << (XLO + 1)) + SQW'(ll_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
         sq_ff <= sq_in;
      end
   end

   assign sq = sq_ff;

endmodule

### rtl/core/sphere_capsule_hit_test.sv
// Sphere versus capsule overlap test, top level.
// Eight-stage pipeline; uses sch_pkg and three sch_xsq squarers.
//
// Usage:
//  A request on the req_ channel carries a sphere (center, radius) and a
//  capsule (segment start, segment end, radius), all in fixed point with
//  8 fraction bits. Each request yields exactly one response on the rsp_
//  channel: rsp_hit is 1 when the distance from the sphere center to the
//  segment is strictly below the summed radii.
//  Throughput is one request per cycle while rsp_ready does not stall the
//  output; the pipeline of eight register stages, with valid bits
//  alongside the data, sets it.
//  The test is exact: the interior case compares |d x w|^2 with R^2 * L,
//  using split multipliers so no division is needed.
//  When the receiver holds rsp_ready low with a response waiting, the
//  whole pipeline freezes and req_ready stays low until that response is
//  taken. Nothing is lost or repeated.
//  Synchronous reset clears all valid bits; no request is in flight after.
module sphere_capsule_hit_test
   import sch_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [CW-1:0]  req_sphere_x,
   input  logic signed [CW-1:0]  req_sphere_y,
   input  logic signed [CW-1:0]  req_sphere_z,
   input  logic [RW-1:0]         req_sphere_radius,
   input  logic signed [CW-1:0]  req_seg_start_x,
   input  logic signed [CW-1:0]  req_seg_start_y,
   input  logic signed [CW-1:0]  req_seg_start_z,
   input  logic signed [CW-1:0]  req_seg_end_x,
   input  logic signed [CW-1:0]  req_seg_end_y,
   input  logic signed [CW-1:0]  req_seg_end_z,
   input  logic [RW-1:0]         req_capsule_radius,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit
);

   logic       en;
   logic [7:0] vld_ff, vld_in;

   // A stage advances whenever the final one is empty or being drained.
   assign en        = !vld_ff[7] || rsp_ready;
   assign req_ready = en;
   assign vld_in    = {vld_ff[6:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: differences and summed radii.
   logic signed [DW-1:0] p_c [3], s_c [3], e_c [3];
   logic signed [DW-1:0] d_ff [3], d_in [3];
   logic signed [DW-1:0] w_ff [3], w_in [3];
   logic signed [DW-1:0] v_ff [3], v_in [3];
   logic [RSW-1:0]       r1_ff, r1_in;

   assign p_c[0] = DW'(req_sphere_x);
   assign p_c[1] = DW'(req_sphere_y);
   assign p_c[2] = DW'(req_sphere_z);
   assign s_c[0] = DW'(req_seg_start_x);
   assign s_c[1] = DW'(req_seg_start_y);
   assign s_c[2] = DW'(req_seg_start_z);
   assign e_c[0] = DW'(req_seg_end_x);
   assign e_c[1] = DW'(req_seg_end_y);
   assign e_c[2] = DW'(req_seg_end_z);
   assign r1_in  = RSW'(req_sphere_radius) + RSW'(req_capsule_radius);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = e_c[i] - s_c[i];
         w_in[i] = p_c[i] - s_c[i];
         v_in[i] = p_c[i] - e_c[i];
      end
   end

   // Stage 2: all narrow products.
   logic signed [PW-1:0] dd_ff [3], dd_in [3];
   logic signed [PW-1:0] wd_ff [3], wd_in [3];
   logic signed [PW-1:0] ww_ff [3], ww_in [3];
   logic signed [PW-1:0] vv_ff [3], vv_in [3];
   logic signed [PW-1:0] pa_ff [3], pa_in [3];
   logic signed [PW-1:0] pb_ff [3], pb_in [3];
   logic [2*RSW-1:0]     r2_ff, r2_in;
   logic [RSW-1:0]       r2r_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd_in[i] = PW'(d_ff[i]) * PW'(d_ff[i]);
         wd_in[i] = PW'(w_ff[i]) * PW'(d_ff[i]);
         ww_in[i] = PW'(w_ff[i]) * PW'(w_ff[i]);
         vv_in[i] = PW'(v_ff[i]) * PW'(v_ff[i]);
      end
      pa_in[0] = PW'(d_ff[1]) * PW'(w_ff[2]);
      pb_in[0] = PW'(d_ff[2]) * PW'(w_ff[1]);
      pa_in[1] = PW'(d_ff[2]) * PW'(w_ff[0]);
      pb_in[1] = PW'(d_ff[0]) * PW'(w_ff[2]);
      pa_in[2] = PW'(d_ff[0]) * PW'(w_ff[1]);
      pb_in[2] = PW'(d_ff[1]) * PW'(w_ff[0]);
   end
   assign r2_in = (2*RSW)'(r1_ff) * (2*RSW)'(r1_ff);

   // Stage 3: dot products and cross product.
   logic signed [SW-1:0] den_ff, den_in, tn_ff, tn_in;
   logic signed [SW-1:0] sww_ff, sww_in, svv_ff, svv_in;
   logic signed [SW-1:0] cr_ff [3], cr_in [3];
   logic [2*RSW-1:0]     r3sq_ff;
   logic [RSW-1:0]       r3_ff;

   assign den_in = SW'(dd_ff[0]) + SW'(dd_ff[1]) + SW'(dd_ff[2]);
   assign tn_in  = SW'(wd_ff[0]) + SW'(wd_ff[1]) + SW'(wd_ff[2]);
   assign sww_in = SW'(ww_ff[0]) + SW'(ww_ff[1]) + SW'(ww_ff[2]);
   assign svv_in = SW'(vv_ff[0]) + SW'(vv_ff[1]) + SW'(vv_ff[2]);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cr_in[i] = SW'(pa_ff[i]) - SW'(pb_ff[i]);
      end
   end

   // Stage 4: case selection, endpoint test, partial products of R * L.
   logic                 use_start, use_end;
   logic signed [SW-1:0] ep_dist;
   logic [LW-1:0]        len;
   logic [XW-1:0]        xabs [3];
   logic                 in4_ff, in4_in, eh4_ff, eh4_in;
   logic [RSW+LLO-1:0]   rlo_ff, rlo_in;
   logic [RSW+LHI-1:0]   rhi_ff, rhi_in;
   logic [RSW-1:0]       r4_ff;

   // A zero-length segment or a projection at or before the start uses S.
   assign use_start = (den_ff == '0) || (tn_ff <= 0);
   assign use_end   = !use_start && (tn_ff >= den_ff);
   assign ep_dist   = use_start ? sww_ff : svv_ff;
   assign eh4_in    = ep_dist < $signed(SW'(r3sq_ff));
   assign in4_in    = !use_start && !use_end;
   assign len       = den_ff[LW-1:0];
   assign rlo_in    = (RSW+LLO)'(r3_ff) * (RSW+LLO)'(len[LLO-1:0]);
   assign rhi_in    = (RSW+LHI)'(r3_ff) * (RSW+LHI)'(len[LW-1:LLO]);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xabs[i] = cr_ff[i][SW-1] ? XW'(-cr_ff[i]) : XW'(cr_ff[i]);
      end
   end

   logic [SQW-1:0] csq [3];

   for (genvar g = 0; g < 3; g++) begin : g_sq
      sch_xsq u_xsq (
         .clock (clock),
         .en    (en),
         .x     (xabs[g]),
         .sq    (csq[g])
      );
   end

   // Stage 5: assemble R * L.
   logic [RLW-1:0] rl5_ff, rl5_in;
   logic [RSW-1:0] r5_ff;
   logic           in5_ff, eh5_ff;

   assign rl5_in = RLW'(rlo_ff) + (RLW'(rhi_ff) << LLO);

   // Stage 6: squared length of the cross product, R * (R * L) in chunks.
   logic [LHSW-1:0]      lhs6_ff, lhs6_in;
   logic [3*RLC-1:0]     rlx;
   logic [RSW+RLC-1:0]   m_ff [3], m_in [3];
   logic                 in6_ff, eh6_ff;

   assign lhs6_in = LHSW'(csq[0]) + LHSW'(csq[1]) + LHSW'(csq[2]);
   assign rlx     = (3*RLC)'(rl5_ff);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_in[i] = (RSW+RLC)'(r5_ff) * (RSW+RLC)'(rlx[i*RLC +: RLC]);
      end
   end

   // Stage 7: R^2 * L.
   logic [RHSW-1:0] rhs7_ff, rhs7_in;
   logic [LHSW-1:0] lhs7_ff;
   logic            in7_ff, eh7_ff;

   assign rhs7_in = RHSW'(m_ff[0]) + (RHSW'(m_ff[1]) << RLC) + (RHSW'(m_ff[2]) << (2 * RLC));

   // Stage 8: final compare into the output register.
   logic hit_ff, hit_in;

   assign hit_in = in7_ff ? (LHSW'(lhs7_ff) < LHSW'(rhs7_ff)) : eh7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         w_ff    <= w_in;
         v_ff    <= v_in;
         r1_ff   <= r1_in;
         dd_ff   <= dd_in;
         wd_ff   <= wd_in;
         ww_ff   <= ww_in;
         vv_ff   <= vv_in;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         r2_ff   <= r2_in;
         r2r_ff  <= r1_ff;
         den_ff  <= den_in;
         tn_ff   <= tn_in;
         sww_ff  <= sww_in;
         svv_ff  <= svv_in;
         cr_ff   <= cr_in;
         r3sq_ff <= r2_ff;
         r3_ff   <= r2r_ff;
         in4_ff  <= in4_in;
         eh4_ff  <= eh4_in;
         rlo_ff  <= rlo_in;
         rhi_ff  <= rhi_in;
         r4_ff   <= r3_ff;
         rl5_ff  <= rl5_in;
         r5_ff   <= r4_ff;
         in5_ff  <= in4_ff;
         eh5_ff  <= eh4_ff;
         lhs6_ff <= lhs6_in;
         m_ff    <= m_in;
         in6_ff  <= in5_ff;
         eh6_ff  <= eh5_ff;
         rhs7_ff <= rhs7_in;
         lhs7_ff <= lhs6_ff;
         in7_ff  <= in6_ff;
         eh7_ff  <= eh6_ff;
         hit_ff  <= hit_in;
      end
   end

   assign rsp_valid = vld_ff[7];
   assign rsp_hit   = hit_ff;

endmodule

### rtl/core/sch_check.sv
// Port-level checker for the sphere/capsule hit test, with its bind.
// Depends on sch_pkg and sphere_capsule_hit_test.
module sch_check
   import sch_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit
);

   // A waiting response holds its value.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit))
      else $error("response changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response present after reset");

   // The input side is stalled only when a response is stuck at the output.
   a_ready_rule : assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request side stalled without output backpressure");

   // A freshly emptied pipeline cannot produce a response next cycle.
   a_no_early : assert property (@(posedge clock)
      reset ##1 !req_valid |=> !rsp_valid)
      else $error("response appeared without a request");

endmodule

bind sphere_capsule_hit_test sch_check u_sch_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_hit   (rsp_hit)
);

### tb/sphere_capsule_hit_test_test.sv
// Testbench for sphere_capsule_hit_test: directed and random overlap queries
// checked against an exact integer predictor. Depends on sch_pkg and the RTL.
module sphere_capsule_hit_test_test;
   import sch_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic signed [CW-1:0] px, py, pz, sx, sy, sz, ex, ey, ez;
      logic [RW-1:0]        rp, rc;
   } query_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [CW-1:0] req_sphere_x = '0, req_sphere_y = '0, req_sphere_z = '0;
   logic [RW-1:0] req_sphere_radius = '0, req_capsule_radius = '0;
   logic signed [CW-1:0] req_seg_start_x = '0, req_seg_start_y = '0, req_seg_start_z = '0;
   logic signed [CW-1:0] req_seg_end_x = '0, req_seg_end_y = '0, req_seg_end_z = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_hit;

   bit   expected_hits[$];
   int   mismatches = 0;
   int   idle_pct_send = 0;
   int   idle_pct_recv = 0;
   int   idle_cycles = 0;
   int   sent = 0, received = 0, hits_seen = 0;
   bit   timed_out = 0;

   sphere_capsule_hit_test u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Exact overlap test on the raw fixed-point integers.
   function automatic bit predict_hit(query_type q);
      longint signed d[3], w[3], v[3];
      logic signed [191:0] den, tn, rsq, sq_dist, cx, cy, cz, lhs;
      longint unsigned rs;
      d[0] = longint'(q.ex) - longint'(q.sx);
      d[1] = longint'(q.ey) - longint'(q.sy);
      d[2] = longint'(q.ez) - longint'(q.sz);
      w[0] = longint'(q.px) - longint'(q.sx);
      w[1] = longint'(q.py) - longint'(q.sy);
      w[2] = longint'(q.pz) - longint'(q.sz);
      v[0] = longint'(q.px) - longint'(q.ex);
      v[1] = longint'(q.py) - longint'(q.ey);
      v[2] = longint'(q.pz) - longint'(q.ez);
      rs  = longint'(q.rp) + longint'(q.rc);
      rsq = 192'(rs * rs);
      den = 192'(d[0]*d[0]) + 192'(d[1]*d[1]) + 192'(d[2]*d[2]);
      tn  = 192'(signed'(w[0]*d[0])) + 192'(signed'(w[1]*d[1]))
            + 192'(signed'(w[2]*d[2]));
      if (den <= 0 || tn <= 0) begin
         sq_dist = 192'(w[0]*w[0]) + 192'(w[1]*w[1]) + 192'(w[2]*w[2]);
         return sq_dist < rsq;
      end
      if (tn >= den) begin
         sq_dist = 192'(v[0]*v[0]) + 192'(v[1]*v[1]) + 192'(v[2]*v[2]);
         return sq_dist < rsq;
      end
      cx = 192'(signed'(d[1]*w[2])) - 192'(signed'(d[2]*w[1]));
      cy = 192'(signed'(d[2]*w[0])) - 192'(signed'(d[0]*w[2]));
      cz = 192'(signed'(d[0]*w[1])) - 192'(signed'(d[1]*w[0]));
      lhs = cx*cx + cy*cy + cz*cz;
      return lhs < rsq * den;
   endfunction

   // Valid stays high between back-to-back requests; it drops only in idle cycles.
   task automatic send_query(query_type q);
      while (idle_pct_send > 0 && $urandom_range(99) < idle_pct_send) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_sphere_x <= q.px; req_sphere_y <= q.py; req_sphere_z <= q.pz;
      req_seg_start_x <= q.sx; req_seg_start_y <= q.sy; req_seg_start_z <= q.sz;
      req_seg_end_x <= q.ex; req_seg_end_y <= q.ey; req_seg_end_z <= q.ez;
      req_sphere_radius <= q.rp; req_capsule_radius <= q.rc;
      do @(posedge clock); while (!req_ready);
      expected_hits = {expected_hits, predict_hit(q)};
      sent++;
   endtask

   // Receiver side: random stall, checking and the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            received++;
            if (rsp_hit) hits_seen++;
            if (expected_hits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response hit=%0b", rsp_hit);
            end else if (expected_hits.pop_front() !== rsp_hit) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d: expected hit=%0b actual %0b",
                           received, !rsp_hit, rsp_hit);
            end
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1;
      end
      rsp_ready <= !(idle_pct_recv > 0 && $urandom_range(99) < idle_pct_recv);
   end

   function automatic logic signed [CW-1:0] rand_coord(int spread);
      int v;
      case ($urandom_range(3))
         0: v = $urandom;
         1: v = $urandom_range(2 * spread) - spread;
         2: v = $urandom_range(1) ? -(1 << (CW-1)) : (1 << (CW-1)) - 1;
         default: v = $urandom_range(1 << 16) - (1 << 15);
      endcase
      return v[CW-1:0];
   endfunction

   function automatic query_type rand_query();
      query_type q;
      int spread;
      spread = 1 << $urandom_range(4, CW-1);
      q.sx = rand_coord(spread); q.sy = rand_coord(spread); q.sz = rand_coord(spread);
      q.ex = $urandom_range(4) == 0 ? q.sx : rand_coord(spread);
      q.ey = rand_coord(spread); q.ez = rand_coord(spread);
      if ($urandom_range(1)) begin
         // Center near the segment so both outcomes are likely.
         q.px = CW'(q.sx + (q.ex - q.sx) / 2 + int'($urandom_range(spread)) - spread / 2);
         q.py = CW'(q.sy + (q.ey - q.sy) / 2 + int'($urandom_range(spread)) - spread / 2);
         q.pz = CW'(q.sz + (q.ez - q.sz) / 2 + int'($urandom_range(spread)) - spread / 2);
      end else begin
         q.px = rand_coord(spread); q.py = rand_coord(spread); q.pz = rand_coord(spread);
      end
      q.rp = $urandom_range(3) == 0 ? RW'($urandom) : RW'($urandom_range(spread / 2));
      q.rc = $urandom_range(3) == 0 ? RW'($urandom) : RW'($urandom_range(spread / 2));
      return q;
   endfunction

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_hits.size() != 0 && !timed_out) @(posedge clock);
   endtask

   task automatic test_directed();
      query_type q;
      // Touching along x: not a hit; one unit closer is.
      q = '{px:2560, py:0, pz:0, sx:0, sy:0, sz:0, ex:0, ey:1024, ez:0, rp:1280, rc:1280};
      send_query(q);
      q.px = 2559; send_query(q);
      // Zero-length segment.
      q = '{px:100, py:100, pz:100, sx:0, sy:0, sz:0, ex:0, ey:0, ez:0, rp:100, rc:74};
      send_query(q);
      q.rc = 74 + 100; send_query(q);
      // Projection exactly at start and exactly at end.
      q = '{px:300, py:0, pz:0, sx:0, sy:0, sz:0, ex:0, ey:500, ez:0, rp:150, rc:151};
      send_query(q);
      q.py = 500; send_query(q);
      q.py = 900; send_query(q);
      q.py = -400; send_query(q);
      // Interior point, touching and overlapping.
      q = '{px:0, py:250, pz:400, sx:0, sy:0, sz:0, ex:0, ey:500, ez:0, rp:200, rc:200};
      send_query(q);
      q.rc = 201; send_query(q);
      // Extremes of every field.
      q = '{px:-(1<<23), py:-(1<<23), pz:-(1<<23), sx:(1<<23)-1, sy:(1<<23)-1,
            sz:(1<<23)-1, ex:-(1<<23), ey:(1<<23)-1, ez:-(1<<23),
            rp:(1<<RW)-1, rc:(1<<RW)-1};
      send_query(q);
      q.rp = 0; q.rc = 0; send_query(q);
      q = '{px:(1<<23)-1, py:(1<<23)-1, pz:(1<<23)-1, sx:-(1<<23), sy:-(1<<23),
            sz:-(1<<23), ex:(1<<23)-1, ey:-(1<<23), ez:(1<<23)-1, rp:0, rc:(1<<RW)-1};
      send_query(q);
      q.rp = (1<<RW)-1; q.rc = 0; send_query(q);
      q = '{px:(1<<23)-1, py:-1, pz:0, sx:-(1<<23), sy:-(1<<23), sz:-(1<<23),
            ex:(1<<23)-1, ey:(1<<23)-1, ez:(1<<23)-1, rp:(1<<RW)-1, rc:(1<<RW)-1};
      send_query(q);
      q = '{px:0, py:0, pz:0, sx:0, sy:0, sz:0, ex:0, ey:0, ez:0, rp:0, rc:0};
      send_query(q);
      q.rp = 1; send_query(q);
      wait_drained();
   endtask

   task automatic test_random(int count, int send_pct, int recv_pct);
      idle_pct_send = send_pct;
      idle_pct_recv = recv_pct;
      repeat (count) begin
         if (timed_out) return;
         send_query(rand_query());
      end
      // The sender holds off until every pending response is back.
      wait_drained();
      idle_pct_send = 0;
      idle_pct_recv = 0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(440, 0, 0);
      test_random(440, 46, 0);
      test_random(440, 0, 46);
      test_random(440, 24, 24);
      wait_drained();
      repeat (20) @(posedge clock);
      if (timed_out) begin
         $display("Regression FAIL");
         $finish;
      end
      $display("Sent %0d queries, %0d responses checked, %0d hits, %0d mismatches.",
               sent, received, hits_seen, mismatches);
      $display("Covered touching, zero-length segment, clamping at both ends, field extremes.");
      if (mismatches == 0 && expected_hits.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      wait (timed_out);
      $display("Watchdog expired, %0d responses outstanding", expected_hits.size());
      $display("Regression FAIL");
      $finish;
   end
endmodule

### files.f
rtl/core/sch_pkg.sv
rtl/core/sch_xsq.sv
rtl/core/sphere_capsule_hit_test.sv
rtl/core/sch_check.sv
tb/sphere_capsule_hit_test_test.sv
